### rtl/core/msde_pkg.sv
// Shared types and constants for the multichannel switch debouncer.
package msde_pkg;

	localparam int CH_IN_W     = 3;
	localparam int NOW_W       = 48;
	localparam int DT_W        = 24;
	localparam int MASK_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 2'd1;

	localparam logic [DT_W-1:0]   DEBOUNCE_RESET = 24'd50000;
	localparam logic [MASK_W-1:0] MASK_RESET     = 8'd0;

	// Debouncer verdict handed to the event tracker
	typedef struct packed {
		logic ch_ok;
		logic filtered;
	} deb_res_t;

	// Result beat fields
	typedef struct packed {
		logic event_initial;
		logic event_valid;
		logic raw_echo;
		logic filtered_state;
	} result_t;

endpackage

### rtl/core/msde_debounce.sv
// Per-channel debounce state and the combinational update of one sample.
module msde_debounce #(
	parameter int NUM_CHANNELS = 8,
	parameter int TIME_BITS    = 48,
	parameter int CH_W         = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [msde_pkg::CH_IN_W-1:0]  channel,
	input  logic [CH_W-1:0]               ch_idx,
	input  logic                          raw_level,
	input  logic [msde_pkg::NOW_W-1:0]    now_us,
	input  logic [msde_pkg::DT_W-1:0]     debounce_time_us,
	input  logic [msde_pkg::MASK_W-1:0]   active_low_mask,
	output msde_pkg::deb_res_t            res
);
	import msde_pkg::*;

	localparam int CMP_W = (TIME_BITS > DT_W) ? TIME_BITS : DT_W;

	logic [NUM_CHANNELS-1:0] seeded_q;
	logic [NUM_CHANNELS-1:0] stable_q;
	logic [NUM_CHANNELS-1:0] cand_q;
	logic [TIME_BITS-1:0]    start_q [NUM_CHANNELS];

	logic                 ch_ok;
	logic                 active;
	logic                 cur_seeded;
	logic                 cur_stable;
	logic                 cur_cand;
	logic [TIME_BITS-1:0] cur_start;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 held;
	logic                 nxt_stable;
	logic                 nxt_cand;
	logic                 load_start;

	assign ch_ok      = int'(channel) < NUM_CHANNELS;
	assign active     = raw_level ^ active_low_mask[channel];
	assign cur_seeded = seeded_q[ch_idx];
	assign cur_stable = stable_q[ch_idx];
	assign cur_cand   = cand_q[ch_idx];
	assign cur_start  = start_q[ch_idx];
	assign now_t      = TIME_BITS'(now_us);
	// wraps modulo 2^TIME_BITS by width
	assign elapsed    = now_t - cur_start;
	assign held       = CMP_W'(elapsed) >= CMP_W'(debounce_time_us);

	always_comb begin
		nxt_stable = cur_stable;
		nxt_cand   = cur_cand;
		load_start = 1'b0;
		if (!cur_seeded) begin
			nxt_stable = active;
			nxt_cand   = active;
			load_start = 1'b1;
		end else if (active != cur_stable) begin
			if (active != cur_cand) begin
				nxt_cand   = active;
				load_start = 1'b1;
			end else if (held) begin
				nxt_stable = cur_cand;
			end
		end else begin
			nxt_cand   = active;
			load_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= '0;
			stable_q <= '0;
			cand_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				start_q[i] <= '0;
			end
		end else if (go && ch_ok) begin
			seeded_q[ch_idx] <= 1'b1;
			stable_q[ch_idx] <= nxt_stable;
			cand_q[ch_idx]   <= nxt_cand;
			if (load_start) begin
				start_q[ch_idx] <= now_t;
			end
		end
	end

	assign res.ch_ok    = ch_ok;
	assign res.filtered = ch_ok & nxt_stable;

endmodule

### rtl/core/msde_events.sv
// Link session tracking and per-channel event memory.
module msde_events #(
	parameter int NUM_CHANNELS = 8,
	parameter int CH_W         = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic               link_up,
	input  logic [CH_W-1:0]    ch_idx,
	input  msde_pkg::deb_res_t deb,
	output logic               event_valid,
	output logic               event_initial
);
	import msde_pkg::*;

	logic                    session_q;
	logic [NUM_CHANNELS-1:0] seen_q;
	logic [NUM_CHANNELS-1:0] level_q;

	logic                    link_edge;
	logic                    cur_seen;
	logic                    cur_level;
	logic [NUM_CHANNELS-1:0] seen_nxt;
	logic [NUM_CHANNELS-1:0] level_nxt;

	// either link transition wipes the event memory
	assign link_edge = link_up != session_q;
	assign cur_seen  = !link_edge && seen_q[ch_idx];
	assign cur_level = !link_edge && level_q[ch_idx];

	assign event_valid   = link_up && deb.ch_ok && (!cur_seen || cur_level != deb.filtered);
	assign event_initial = event_valid && !cur_seen;

	always_comb begin
		seen_nxt  = link_edge ? '0 : seen_q;
		level_nxt = link_edge ? '0 : level_q;
		if (event_valid) begin
			seen_nxt[ch_idx]  = 1'b1;
			level_nxt[ch_idx] = deb.filtered;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 1'b0;
			seen_q    <= '0;
			level_q   <= '0;
		end else if (go) begin
			session_q <= link_up;
			seen_q    <= seen_nxt;
			level_q   <= level_nxt;
		end
	end

endmodule

### rtl/core/multichannel_switch_debounce_events_top.sv
// Top level of the multichannel switch debouncer with change events.
//
// Input stream (s_axis): one beat is one pin sample of one channel; tuser
// carries the channel index, tdata the raw level, the microsecond time stamp
// and the link status. Output stream (m_axis): exactly one beat per input
// beat, in order, with the debounced state, the raw level echo and the event
// flags.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 =
// debounce time in microseconds, 1 = active-low mask); other indexes are
// dropped. Write only while no sample is in flight.
// Path: a beat accepted on s_axis is held in the sample register, then
// written into the result register, which offers it on m_axis.
// Throughput: one beat per cycle unless m_axis stalls. The sample register,
// the debounce update (one time subtract and compare) and the result register
// form one stage, so the next beat reads the channel state each beat writes.
// Stall: while m_axis_tready is low the result register holds; one more
// sample may wait in the input register, then s_axis_tready drops.
// Reset: all channel state, event memory and session flag clear, the
// debounce time returns to 50000 us and the mask to zero.
module multichannel_switch_debounce_events_top #(
	parameter int NUM_CHANNELS = 8,
	parameter int TIME_BITS    = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// raw_level[0], now_us[48:1], link_up[49], zero fill [55:50]
	input  logic [msde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// channel[2:0]
	input  logic [msde_pkg::CH_IN_W-1:0]         s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// filtered_state[0], raw_echo[1], event_valid[2], event_initial[3], zero fill
	output logic [msde_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [msde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msde_pkg::DT_W-1:0]            cfg_wdata
);
	import msde_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [DT_W-1:0]   debounce_time_q;
	logic [MASK_W-1:0] active_low_q;

	logic               valid_s1;
	logic [CH_IN_W-1:0] channel_s1;
	logic               raw_s1;
	logic [NOW_W-1:0]   now_s1;
	logic               link_s1;

	logic    valid_s2;
	result_t result_s2;

	logic           s_accept;
	logic           go;
	logic [CH_W+2:0] ch_ext;
	logic [CH_W-1:0] ch_idx;
	deb_res_t       deb;
	logic           ev_valid;
	logic           ev_initial;

	assign go            = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign ch_ext = (CH_W + 3)'(channel_s1);
	assign ch_idx = ch_ext[CH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= DEBOUNCE_RESET;
			active_low_q    <= MASK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEBOUNCE_TIME: debounce_time_q <= cfg_wdata;
				REG_ACTIVE_LOW:    active_low_q    <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			channel_s1 <= s_axis_tuser;
			raw_s1     <= s_axis_tdata[0];
			now_s1     <= s_axis_tdata[NOW_W:1];
			link_s1    <= s_axis_tdata[NOW_W+1];
		end
	end

	msde_debounce #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.TIME_BITS   (TIME_BITS),
		.CH_W        (CH_W)
	) u_debounce (
		.clk             (clk),
		.arst_n          (arst_n),
		.go              (go),
		.channel         (channel_s1),
		.ch_idx          (ch_idx),
		.raw_level       (raw_s1),
		.now_us          (now_s1),
		.debounce_time_us(debounce_time_q),
		.active_low_mask (active_low_q),
		.res             (deb)
	);

	msde_events #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CH_W        (CH_W)
	) u_events (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.link_up      (link_s1),
		.ch_idx       (ch_idx),
		.deb          (deb),
		.event_valid  (ev_valid),
		.event_initial(ev_initial)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_s2.filtered_state <= deb.filtered;
			result_s2.raw_echo       <= raw_s1;
			result_s2.event_valid    <= ev_valid;
			result_s2.event_initial  <= ev_initial;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(result_s2);

endmodule

### rtl/core/msde_checker.sv
// Port-level checks for the debouncer top, bound to every instance.
module msde_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [msde_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import msde_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// an initial report is always an event
	a_initial_is_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
		else $error("event_initial without event_valid");

	// with the output empty the input side never back-pressures
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a fresh result comes from an accepted sample
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result beat without an accepted sample");

endmodule

bind multichannel_switch_debounce_events_top msde_checker u_msde_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
